[hw/rtl/nfd_pkg.sv]
`timescale 1ns / 1ps

package nfd_pkg;

    // Bytes kept per line.
    localparam int LINE_MAX = 64;
    localparam int LINE_AW  = $clog2(LINE_MAX);
    localparam int LEN_W    = $clog2(LINE_MAX + 1);
    // Two line buffers share one memory; the top address bit picks the buffer.
    localparam int RAM_AW    = LINE_AW + 1;
    localparam int RAM_DEPTH = 2 ** RAM_AW;

    localparam int OUT_DEPTH = 4;
    localparam int OUT_AW    = $clog2(OUT_DEPTH);
    localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

    localparam logic [7:0] BYTE_NUL   = 8'h00;
    localparam logic [7:0] BYTE_BEL   = 8'h07;
    localparam logic [7:0] BYTE_LF    = 8'h0A;
    localparam logic [7:0] BYTE_CR    = 8'h0D;
    localparam logic [7:0] BYTE_NAK   = 8'h15;
    localparam logic [7:0] BYTE_DC4   = 8'h14;
    localparam logic [7:0] BYTE_DC2   = 8'h12;
    localparam logic [7:0] BYTE_MARK  = 8'hF2;
    localparam logic [7:0] BYTE_SPACE = 8'h20;
    localparam logic [7:0] BYTE_SLASH = 8'h2F;
    localparam logic [7:0] BYTE_N     = 8'h4E;
    localparam logic [7:0] BYTE_Y     = 8'h59;
    localparam logic [7:0] BYTE_U     = 8'h55;
    localparam logic [7:0] BYTE_H     = 8'h48;

    localparam logic [2:0] RUN_SAT = 3'd4;
    localparam logic [1:0] PROG_SAT = 2'd2;

    localparam logic [1:0] KIND_TYPE    = 2'd0;
    localparam logic [1:0] KIND_SUBJECT = 2'd1;
    localparam logic [1:0] KIND_BODY    = 2'd2;
    localparam logic [1:0] KIND_END     = 2'd3;

    localparam logic [1:0] PH_WAIT    = 2'd0;
    localparam logic [1:0] PH_TYPE    = 2'd1;
    localparam logic [1:0] PH_SUBJECT = 2'd2;
    localparam logic [1:0] PH_BODY    = 2'd3;

    typedef struct packed {
        logic [1:0]       kind;
        logic             span;   // 0: one result without data
        logic             buf_sel;
        logic [LEN_W-1:0] start;
        logic [LEN_W-1:0] stop;
    } t_job;

    typedef struct packed {
        logic              we;
        logic [RAM_AW-1:0] addr;
        logic [7:0]        data;
    } t_ram_wr;

    typedef struct packed {
        logic valid;
        logic buf_sel;
    } t_release;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       has;
        logic       last;
    } t_res;

endpackage

[hw/rtl/nfd_line_ram.sv]
`timescale 1ns / 1ps

module nfd_line_ram (
    input  logic                      i_clk,
    input  nfd_pkg::t_ram_wr          i_wr,
    input  logic                      i_rd_en,
    input  logic [nfd_pkg::RAM_AW-1:0] i_rd_addr,
    output logic [7:0]                o_rd_data
);

    logic [7:0] r_mem [nfd_pkg::RAM_DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[hw/rtl/nfd_front.sv]
`timescale 1ns / 1ps

module nfd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  logic [7:0]        i_feed_byte,
    input  logic              i_end_of_feed,
    input  logic              i_job_full,
    output logic              o_job_push,
    output nfd_pkg::t_job     o_job,
    output nfd_pkg::t_ram_wr  o_ram_wr,
    input  nfd_pkg::t_release i_release
);

    logic [1:0]                r_phase, n_phase;
    logic [nfd_pkg::LEN_W-1:0] r_len, n_len;
    logic [7:0]                r_b0, n_b0, r_b1, n_b1;
    logic                      r_skipping, n_skipping;
    logic [2:0]                r_run, n_run;
    logic [1:0]                r_prog, n_prog;
    logic                      r_endm, n_endm;
    logic                      r_skipm, n_skipm;
    logic                      r_f2_found, n_f2_found;
    logic [nfd_pkg::LEN_W-1:0] r_f2_pos, n_f2_pos;
    logic                      r_wbuf, n_wbuf;
    logic [1:0]                r_busy, n_busy;

    logic       acc, skip_now, is_cr, keep, store, finish, header_ok, subj_ok;
    logic [7:0] c;
    logic [nfd_pkg::LEN_W-1:0] subj_stop;

    assign o_full = r_busy[r_wbuf] || i_job_full;

    always_comb begin
        acc      = i_push && !o_full;
        skip_now = r_skipping && (i_feed_byte == nfd_pkg::BYTE_CR
                                  || i_feed_byte == nfd_pkg::BYTE_LF);
        is_cr    = !skip_now && i_feed_byte == nfd_pkg::BYTE_CR;
        keep     = !skip_now && i_feed_byte != nfd_pkg::BYTE_CR
                   && i_feed_byte != nfd_pkg::BYTE_NUL;
        priority if (i_feed_byte == nfd_pkg::BYTE_NAK) begin
            c = nfd_pkg::BYTE_SPACE;
        end else if (i_feed_byte == nfd_pkg::BYTE_BEL) begin
            c = nfd_pkg::BYTE_SLASH;
        end else begin
            c = i_feed_byte;
        end
        store = acc && keep && r_len < nfd_pkg::LEN_W'(nfd_pkg::LINE_MAX);

        n_phase    = r_phase;
        n_len      = r_len;
        n_b0       = r_b0;
        n_b1       = r_b1;
        n_skipping = r_skipping;
        n_run      = r_run;
        n_prog     = r_prog;
        n_endm     = r_endm;
        n_skipm    = r_skipm;
        n_f2_found = r_f2_found;
        n_f2_pos   = r_f2_pos;
        n_wbuf     = r_wbuf;
        n_busy     = r_busy;
        if (i_release.valid) begin
            n_busy[i_release.buf_sel] = 1'b0;
        end

        // Marker trackers see only bytes that land in the line.
        if (store) begin
            n_len = r_len + 1'b1;
            if (r_len == '0) begin
                n_b0 = c;
            end
            if (r_len == nfd_pkg::LEN_W'(1)) begin
                n_b1 = c;
            end
            if (c == nfd_pkg::BYTE_N) begin
                if (r_run < nfd_pkg::RUN_SAT) begin
                    n_run = r_run + 1'b1;
                end
                if (n_run >= nfd_pkg::RUN_SAT) begin
                    n_endm = 1'b1;
                end
            end else begin
                n_run = '0;
            end
            if (c == nfd_pkg::BYTE_DC4) begin
                if (r_prog < nfd_pkg::PROG_SAT) begin
                    n_prog = r_prog + 1'b1;
                end
            end else begin
                if (c == nfd_pkg::BYTE_MARK && r_prog == nfd_pkg::PROG_SAT) begin
                    n_skipm = 1'b1;
                end
                n_prog = '0;
            end
            if (c == nfd_pkg::BYTE_MARK && r_len >= nfd_pkg::LEN_W'(2) && !r_f2_found) begin
                n_f2_found = 1'b1;
                n_f2_pos   = r_len;
            end
        end

        if (acc && !skip_now) begin
            n_skipping = is_cr;
        end
        finish = acc && (is_cr || (i_end_of_feed && !n_skipping));

        header_ok = n_len >= nfd_pkg::LEN_W'(2) && n_b0 == n_b1
                    && (n_b0 == nfd_pkg::BYTE_Y || n_b0 == nfd_pkg::BYTE_U
                        || n_b0 == nfd_pkg::BYTE_H);
        subj_ok   = n_len >= nfd_pkg::LEN_W'(2) && n_b0 == nfd_pkg::BYTE_MARK
                    && n_b1 == nfd_pkg::BYTE_DC2;
        subj_stop = n_f2_found ? n_f2_pos : n_len;

        o_job_push    = 1'b0;
        o_job.kind    = nfd_pkg::KIND_TYPE;
        o_job.span    = 1'b0;
        o_job.buf_sel = r_wbuf;
        o_job.start   = '0;
        o_job.stop    = n_len;

        if (finish) begin
            unique case (r_phase)
                nfd_pkg::PH_WAIT: begin
                    if (header_ok) begin
                        n_phase = nfd_pkg::PH_TYPE;
                    end
                end
                nfd_pkg::PH_TYPE: begin
                    o_job_push = 1'b1;
                    o_job.kind = nfd_pkg::KIND_TYPE;
                    o_job.span = n_len != '0;
                    n_phase    = nfd_pkg::PH_SUBJECT;
                end
                nfd_pkg::PH_SUBJECT: begin
                    if (subj_ok) begin
                        o_job_push  = 1'b1;
                        o_job.kind  = nfd_pkg::KIND_SUBJECT;
                        o_job.start = nfd_pkg::LEN_W'(2);
                        o_job.stop  = subj_stop;
                        o_job.span  = subj_stop > nfd_pkg::LEN_W'(2);
                        n_phase     = nfd_pkg::PH_BODY;
                    end
                end
                nfd_pkg::PH_BODY: begin
                    if (n_endm) begin
                        o_job_push = 1'b1;
                        o_job.kind = nfd_pkg::KIND_END;
                        n_phase    = nfd_pkg::PH_WAIT;
                    end else if (!n_skipm) begin
                        o_job_push = 1'b1;
                        o_job.kind = nfd_pkg::KIND_BODY;
                        o_job.span = n_len != '0;
                    end
                end
                default: begin
                end
            endcase

            // A line whose bytes are still to be read pins its buffer.
            if (o_job_push && o_job.span) begin
                n_busy[r_wbuf] = 1'b1;
                n_wbuf         = ~r_wbuf;
            end
        end

        if (finish || (acc && i_end_of_feed)) begin
            n_len      = '0;
            n_run      = '0;
            n_prog     = '0;
            n_endm     = 1'b0;
            n_skipm    = 1'b0;
            n_f2_found = 1'b0;
        end
        if (acc && i_end_of_feed) begin
            n_phase    = nfd_pkg::PH_WAIT;
            n_skipping = 1'b0;
        end

        o_ram_wr.we   = store;
        o_ram_wr.addr = {r_wbuf, r_len[nfd_pkg::LINE_AW-1:0]};
        o_ram_wr.data = c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= nfd_pkg::PH_WAIT;
            r_len      <= '0;
            r_skipping <= 1'b0;
            r_run      <= '0;
            r_prog     <= '0;
            r_endm     <= 1'b0;
            r_skipm    <= 1'b0;
            r_f2_found <= 1'b0;
            r_wbuf     <= 1'b0;
            r_busy     <= '0;
        end else begin
            r_phase    <= n_phase;
            r_len      <= n_len;
            r_skipping <= n_skipping;
            r_run      <= n_run;
            r_prog     <= n_prog;
            r_endm     <= n_endm;
            r_skipm    <= n_skipm;
            r_f2_found <= n_f2_found;
            r_wbuf     <= n_wbuf;
            r_busy     <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b0     <= n_b0;
        r_b1     <= n_b1;
        r_f2_pos <= n_f2_pos;
    end

endmodule

[hw/rtl/nfd_job_fifo.sv]
`timescale 1ns / 1ps

module nfd_job_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  nfd_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output nfd_pkg::t_job o_job
);

    nfd_pkg::t_job r_slot [2];
    logic          r_wp, n_wp, r_rp, n_rp;
    logic [1:0]    r_cnt, n_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_empty = r_cnt == 2'd0;
    assign o_job   = r_slot[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push && !o_full) begin
            n_wp  = ~r_wp;
            n_cnt = n_cnt + 1'b1;
        end
        if (i_pop && !o_empty) begin
            n_rp  = ~r_rp;
            n_cnt = n_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_slot[r_wp] <= i_job;
        end
    end

endmodule

[hw/rtl/nfd_back.sv]
`timescale 1ns / 1ps

module nfd_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_job_empty,
    input  nfd_pkg::t_job              i_job,
    output logic                       o_job_pop,
    output logic                       o_rd_en,
    output logic [nfd_pkg::RAM_AW-1:0] o_rd_addr,
    input  logic [7:0]                 i_rd_data,
    output nfd_pkg::t_release          o_release,
    output logic                       o_empty,
    input  logic                       i_pop,
    output nfd_pkg::t_res              o_res
);

    logic                      r_active, n_active;
    nfd_pkg::t_job             r_job;
    logic [nfd_pkg::LEN_W-1:0] r_idx, n_idx;

    // Stage that holds each beat while the registered memory read completes.
    logic       r_p_valid;
    logic [1:0] r_p_kind;
    logic       r_p_has;
    logic       r_p_last;

    nfd_pkg::t_res             r_q [nfd_pkg::OUT_DEPTH];
    logic [nfd_pkg::OUT_AW-1:0] r_wp, r_rp;
    logic [nfd_pkg::OUT_CW-1:0] r_cnt, n_cnt;

    logic          load, issue, last_now, q_push, q_pop;
    nfd_pkg::t_res q_in;

    always_comb begin
        load      = !r_active && !i_job_empty;
        o_job_pop = load;
        // Credit check covers the beat still in the read stage.
        issue     = r_active && ({1'b0, r_cnt} + {{nfd_pkg::OUT_CW{1'b0}}, r_p_valid})
                    < (nfd_pkg::OUT_CW + 1)'(nfd_pkg::OUT_DEPTH);
        last_now  = !r_job.span || (r_idx + 1'b1) == r_job.stop;

        o_rd_en   = issue && r_job.span;
        o_rd_addr = {r_job.buf_sel, r_idx[nfd_pkg::LINE_AW-1:0]};

        o_release.valid   = issue && last_now && r_job.span;
        o_release.buf_sel = r_job.buf_sel;

        n_active = r_active;
        n_idx    = r_idx;
        if (load) begin
            n_active = 1'b1;
            n_idx    = i_job.start;
        end else if (issue) begin
            n_idx = r_idx + 1'b1;
            if (last_now) begin
                n_active = 1'b0;
            end
        end

        q_push    = r_p_valid;
        q_in.kind = r_p_kind;
        q_in.data = r_p_has ? i_rd_data : 8'h00;
        q_in.has  = r_p_has;
        q_in.last = r_p_last;

        o_empty = r_cnt == '0;
        q_pop   = i_pop && !o_empty;
        o_res   = r_q[r_rp];

        n_cnt = r_cnt;
        if (q_push) begin
            n_cnt = n_cnt + 1'b1;
        end
        if (q_pop) begin
            n_cnt = n_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_p_valid <= 1'b0;
            r_wp      <= '0;
            r_rp      <= '0;
            r_cnt     <= '0;
        end else begin
            r_active  <= n_active;
            r_p_valid <= issue;
            r_cnt     <= n_cnt;
            if (q_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (q_pop) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (load) begin
            r_job <= i_job;
        end
        if (issue) begin
            r_p_kind <= r_job.kind;
            r_p_has  <= r_job.span;
            r_p_last <= last_now;
        end
        if (q_push) begin
            r_q[r_wp] <= q_in;
        end
    end

endmodule

[hw/rtl/news_feed_line_deframer.sv]
`timescale 1ns / 1ps
// Channel   Handshake          Payload
// input     push / full        i_feed_byte, i_end_of_feed
// result    empty / pop        o_line_kind, o_data_byte, o_has_data, o_last_of_line
//
// The front takes one byte per cycle while full is low; the back end picks up
// each kept line from the line queue and reads it back one result per cycle,
// while its result queue has room, from a two-buffer registered line memory.
// full rises while the buffer the next line would fill is still being read
// out, or while two finished lines wait in the line queue.
// Reset is synchronous; the line memory needs no clearing pass.

module news_feed_line_deframer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_feed_byte,
    input  logic       i_end_of_feed,
    output logic       empty,
    input  logic       pop,
    output logic [1:0] o_line_kind,
    output logic [7:0] o_data_byte,
    output logic       o_has_data,
    output logic       o_last_of_line
);

    logic                       job_push, job_full, job_pop, job_empty;
    nfd_pkg::t_job              job_in, job_out;
    nfd_pkg::t_ram_wr           ram_wr;
    nfd_pkg::t_release          release_buf;
    logic                       rd_en;
    logic [nfd_pkg::RAM_AW-1:0] rd_addr;
    logic [7:0]                 rd_data;
    nfd_pkg::t_res              res;

    nfd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_feed_byte   (i_feed_byte),
        .i_end_of_feed (i_end_of_feed),
        .i_job_full    (job_full),
        .o_job_push    (job_push),
        .o_job         (job_in),
        .o_ram_wr      (ram_wr),
        .i_release     (release_buf)
    );

    nfd_job_fifo u_job_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_empty (job_empty),
        .o_job   (job_out)
    );

    nfd_line_ram u_line_ram (
        .i_clk     (i_clk),
        .i_wr      (ram_wr),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    nfd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (job_empty),
        .i_job       (job_out),
        .o_job_pop   (job_pop),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_release   (release_buf),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_res       (res)
    );

    assign o_line_kind    = res.kind;
    assign o_data_byte    = res.data;
    assign o_has_data     = res.has;
    assign o_last_of_line = res.last;

endmodule

[hw/rtl/nfd_checker.sv]
`timescale 1ns / 1ps

module nfd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       empty,
    input logic       pop,
    input logic [1:0] o_line_kind,
    input logic [7:0] o_data_byte,
    input logic       o_has_data,
    input logic       o_last_of_line
);

    // Nothing is left waiting on the result side after a reset.
    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("results visible right after reset");

    a_no_data_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_has_data) |-> (o_data_byte == 8'h00 && o_last_of_line))
        else $error("dataless result carries a byte or is not last");

    a_story_end_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_line_kind == nfd_pkg::KIND_END) |-> !o_has_data)
        else $error("story end result carries data");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_data_byte) && $stable(o_line_kind)))
        else $error("waiting result changed");

endmodule

bind news_feed_line_deframer nfd_checker u_nfd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .empty          (empty),
    .pop            (pop),
    .o_line_kind    (o_line_kind),
    .o_data_byte    (o_data_byte),
    .o_has_data     (o_has_data),
    .o_last_of_line (o_last_of_line)
);

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;

    localparam int HOLD_OFF    = 300;
    localparam int STUCK_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 20;
    localparam int RANDOM_BYTES = 300;

    typedef struct {
        logic [7:0] value;
        logic       eof;
    } t_feed_item;

    // Tracks the line being cut and the story phase, and holds the result
    // beats that the lines closed so far must produce.
    class story_scoreboard;
        nfd_pkg::t_res expected_q[$];
        logic [1:0]    phase;
        logic [7:0]    line_buf[nfd_pkg::LINE_MAX];
        int            line_len;
        bit            skipping;
        int            n_run;
        int            dc4_run;
        bit            saw_end;
        bit            saw_skip;
        int            failures;
        int            bytes_fed;
        int            kind_seen[4];

        function new();
            phase     = nfd_pkg::PH_WAIT;
            skipping  = 1'b0;
            failures  = 0;
            bytes_fed = 0;
            foreach (kind_seen[k]) kind_seen[k] = 0;
            clear_line();
        endfunction

        function void clear_line();
            line_len = 0;
            n_run    = 0;
            dc4_run  = 0;
            saw_end  = 1'b0;
            saw_skip = 1'b0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Queues bytes [first, stop) of the line, or a single empty beat.
        function void emit_span(logic [1:0] kind, int first, int stop);
            nfd_pkg::t_res r;
            r.kind = kind;
            if (stop <= first) begin
                r.data = nfd_pkg::BYTE_NUL;
                r.has  = 1'b0;
                r.last = 1'b1;
                expected_q.push_back(r);
                return;
            end
            for (int i = first; i < stop; i++) begin
                r.data = line_buf[i];
                r.has  = 1'b1;
                r.last = (i + 1 == stop);
                expected_q.push_back(r);
            end
        endfunction

        function void close_line();
            logic [7:0]    b0;
            logic [7:0]    b1;
            int            stop;
            nfd_pkg::t_res r;
            b0 = (line_len > 0) ? line_buf[0] : nfd_pkg::BYTE_NUL;
            b1 = (line_len > 1) ? line_buf[1] : nfd_pkg::BYTE_NUL;
            case (phase)
                nfd_pkg::PH_WAIT: begin
                    if (line_len >= 2 && b0 == b1
                            && (b0 == nfd_pkg::BYTE_Y || b0 == nfd_pkg::BYTE_U
                                || b0 == nfd_pkg::BYTE_H))
                        phase = nfd_pkg::PH_TYPE;
                end
                nfd_pkg::PH_TYPE: begin
                    emit_span(nfd_pkg::KIND_TYPE, 0, line_len);
                    phase = nfd_pkg::PH_SUBJECT;
                end
                nfd_pkg::PH_SUBJECT: begin
                    if (line_len >= 2 && b0 == nfd_pkg::BYTE_MARK
                            && b1 == nfd_pkg::BYTE_DC2) begin
                        stop = 2;
                        while (stop < line_len && line_buf[stop] != nfd_pkg::BYTE_MARK)
                            stop++;
                        emit_span(nfd_pkg::KIND_SUBJECT, 2, stop);
                        phase = nfd_pkg::PH_BODY;
                    end
                end
                default: begin
                    if (saw_end) begin
                        r.kind = nfd_pkg::KIND_END;
                        r.data = nfd_pkg::BYTE_NUL;
                        r.has  = 1'b0;
                        r.last = 1'b1;
                        expected_q.push_back(r);
                        phase = nfd_pkg::PH_WAIT;
                    end else if (!saw_skip) begin
                        emit_span(nfd_pkg::KIND_BODY, 0, line_len);
                    end
                end
            endcase
            clear_line();
        endfunction

        function void note_feed_byte(logic [7:0] b, logic eof);
            logic [7:0] c;
            bytes_fed++;
            if (!(skipping && (b == nfd_pkg::BYTE_CR || b == nfd_pkg::BYTE_LF))) begin
                skipping = 1'b0;
                if (b == nfd_pkg::BYTE_CR) begin
                    close_line();
                    skipping = 1'b1;
                end else if (b != nfd_pkg::BYTE_NUL && line_len < nfd_pkg::LINE_MAX) begin
                    c = (b == nfd_pkg::BYTE_NAK) ? nfd_pkg::BYTE_SPACE
                        : (b == nfd_pkg::BYTE_BEL) ? nfd_pkg::BYTE_SLASH : b;
                    line_buf[line_len] = c;
                    line_len++;
                    if (c == nfd_pkg::BYTE_N) begin
                        if (n_run < nfd_pkg::RUN_SAT) n_run++;
                        if (n_run >= nfd_pkg::RUN_SAT) saw_end = 1'b1;
                    end else begin
                        n_run = 0;
                    end
                    if (c == nfd_pkg::BYTE_DC4) begin
                        if (dc4_run < nfd_pkg::PROG_SAT) dc4_run++;
                    end else begin
                        if (c == nfd_pkg::BYTE_MARK && dc4_run == nfd_pkg::PROG_SAT)
                            saw_skip = 1'b1;
                        dc4_run = 0;
                    end
                end
            end
            if (eof) begin
                if (!skipping) close_line();
                phase    = nfd_pkg::PH_WAIT;
                skipping = 1'b0;
                clear_line();
            end
        endfunction

        function void check_result(logic [1:0] kind, logic [7:0] data, logic has,
                                   logic last);
            nfd_pkg::t_res want;
            if (expected_q.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("Unexpected result beat: kind %0d data %02h has %0b last %0b",
                             kind, data, has, last);
                return;
            end
            want = expected_q.pop_front();
            kind_seen[want.kind]++;
            if (want.kind !== kind || want.data !== data || want.has !== has
                    || want.last !== last) begin
                failures++;
                if (failures <= 10)
                    $display("Mismatch: expected kind %0d data %02h has %0b last %0b, %s",
                             want.kind, want.data, want.has, want.last,
                             $sformatf("got kind %0d data %02h has %0b last %0b",
                                       kind, data, has, last));
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       push;
    logic       full;
    logic [7:0] i_feed_byte;
    logic       i_end_of_feed;
    logic       empty;
    logic       pop;
    logic [1:0] o_line_kind;
    logic [7:0] o_data_byte;
    logic       o_has_data;
    logic       o_last_of_line;

    story_scoreboard sb;
    t_feed_item      feed_q[$];
    int              stories;
    int              popped;
    int              stuck_cycles;

    news_feed_line_deframer u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_feed_byte   (i_feed_byte),
        .i_end_of_feed (i_end_of_feed),
        .empty         (empty),
        .pop           (pop),
        .o_line_kind   (o_line_kind),
        .o_data_byte   (o_data_byte),
        .o_has_data    (o_has_data),
        .o_last_of_line(o_last_of_line)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Ends the run when neither side has moved a beat for too long.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("Timeout: no beat moved in %0d cycles", STUCK_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic add_item(logic [7:0] b, logic eof = 1'b0);
        t_feed_item it;
        it.value = b;
        it.eof   = eof;
        feed_q.push_back(it);
    endtask

    // Line content, rich in the bytes that the cleaner and the markers react to.
    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        case ($urandom_range(0, 19))
            0: b = nfd_pkg::BYTE_NUL;
            1: b = nfd_pkg::BYTE_NAK;
            2: b = nfd_pkg::BYTE_BEL;
            3: b = nfd_pkg::BYTE_DC4;
            4: b = nfd_pkg::BYTE_MARK;
            5, 6: b = nfd_pkg::BYTE_N;
            7: b = nfd_pkg::BYTE_LF;
            default: begin
                b = 8'($urandom_range(0, 255));
                if (b == nfd_pkg::BYTE_CR) b = nfd_pkg::BYTE_SPACE;
            end
        endcase
        return b;
    endfunction

    function automatic int text_len();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(nfd_pkg::LINE_MAX - 2, nfd_pkg::LINE_MAX + 12);
        return $urandom_range(0, 10);
    endfunction

    // An empty line still needs a byte that ends the terminator skip.
    task automatic add_text(int n);
        if (n == 0) add_item(nfd_pkg::BYTE_NUL);
        repeat (n) add_item(text_byte());
    endtask

    task automatic add_cut();
        add_item(nfd_pkg::BYTE_CR);
        repeat ($urandom_range(0, 3))
            add_item($urandom_range(0, 1) ? nfd_pkg::BYTE_CR : nfd_pkg::BYTE_LF);
    endtask

    task automatic add_story();
        logic [7:0] h;
        int         r;
        r = $urandom_range(0, 7);
        h = (r < 3) ? nfd_pkg::BYTE_Y : (r < 5) ? nfd_pkg::BYTE_U
            : (r < 7) ? nfd_pkg::BYTE_H : text_byte();
        add_item(h);
        add_item(($urandom_range(0, 7) == 0) ? text_byte() : h);
        add_text($urandom_range(0, 6));
        add_cut();
        add_text(text_len());
        add_cut();
        if ($urandom_range(0, 5) == 0) begin
            add_text($urandom_range(1, 6));
            add_cut();
        end
        add_item(nfd_pkg::BYTE_MARK);
        add_item(nfd_pkg::BYTE_DC2);
        add_text($urandom_range(0, 8));
        if ($urandom_range(0, 2) == 0) begin
            add_item(nfd_pkg::BYTE_MARK);
            add_text($urandom_range(0, 4));
        end
        add_cut();
        repeat ($urandom_range(1, 5)) begin
            if ($urandom_range(0, 5) == 0) begin
                add_text($urandom_range(0, 3));
                add_item(nfd_pkg::BYTE_DC4);
                add_item(nfd_pkg::BYTE_DC4);
                add_item(nfd_pkg::BYTE_MARK);
                add_text($urandom_range(0, 3));
            end else begin
                add_text(text_len());
            end
            add_cut();
        end
        if ($urandom_range(0, 7) == 0) begin
            // The feed ends in the middle of the story.
            add_text($urandom_range(0, 4));
            feed_q[feed_q.size() - 1].eof = 1'b1;
        end else begin
            add_text($urandom_range(0, 3));
            repeat ($urandom_range(4, 5)) add_item(nfd_pkg::BYTE_N);
            add_text($urandom_range(0, 3));
            add_cut();
        end
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                repeat ($urandom_range(0, 8)) add_item(8'($urandom_range(0, 255)));
                add_item(nfd_pkg::BYTE_CR, $urandom_range(0, 3) == 0);
            end
        end
        stories++;
    endtask

    task automatic add_opening();
        logic [7:0] opening[] = '{
            nfd_pkg::BYTE_H, nfd_pkg::BYTE_H, nfd_pkg::BYTE_CR, nfd_pkg::BYTE_LF,
            nfd_pkg::BYTE_NUL, nfd_pkg::BYTE_CR,
            nfd_pkg::BYTE_MARK, nfd_pkg::BYTE_DC2, nfd_pkg::BYTE_BEL, nfd_pkg::BYTE_NAK,
            nfd_pkg::BYTE_MARK, "A", nfd_pkg::BYTE_CR,
            8'hFF, nfd_pkg::BYTE_LF, nfd_pkg::BYTE_N, nfd_pkg::BYTE_CR,
            nfd_pkg::BYTE_DC4, nfd_pkg::BYTE_DC4, nfd_pkg::BYTE_MARK, nfd_pkg::BYTE_CR,
            nfd_pkg::BYTE_N, nfd_pkg::BYTE_N, nfd_pkg::BYTE_N, nfd_pkg::BYTE_N,
            nfd_pkg::BYTE_CR
        };
        foreach (opening[i]) add_item(opening[i]);
        add_item("X", 1'b1);
    endtask

    task automatic send_feed();
        int gap;
        bit burst;
        foreach (feed_q[i]) begin
            if (i % 32 == 0) burst = ($urandom_range(0, 3) == 0);
            gap = burst ? 0 : $urandom_range(0, 4);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            push          <= 1'b1;
            i_feed_byte   <= feed_q[i].value;
            i_end_of_feed <= feed_q[i].eof;
            @(posedge i_clk);
            while (full) @(posedge i_clk);
            sb.note_feed_byte(feed_q[i].value, feed_q[i].eof);
        end
        push <= 1'b0;
    endtask

    task automatic drain_results();
        int gap;
        bit burst;
        forever begin
            if (popped % 32 == 0) burst = ($urandom_range(0, 3) == 0);
            gap = burst ? 0 : $urandom_range(0, 4);
            // Long holds let the line buffers fill so that full rises.
            if (popped == 15 || popped == 60) gap = HOLD_OFF;
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
            while (empty) @(posedge i_clk);
            sb.check_result(o_line_kind, o_data_byte, o_has_data, o_last_of_line);
            popped++;
        end
    endtask

    initial begin
        int opening_len;
        i_rst_n       <= 1'b0;
        push          <= 1'b0;
        pop           <= 1'b0;
        i_feed_byte   <= nfd_pkg::BYTE_NUL;
        i_end_of_feed <= 1'b0;
        stories      = 0;
        popped       = 0;
        stuck_cycles = 0;
        sb = new();
        add_opening();
        opening_len = feed_q.size();
        while (feed_q.size() < opening_len + RANDOM_BYTES) add_story();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        fork
            drain_results();
        join_none
        send_feed();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        $display("Fed %0d bytes (%0d random stories), checked %0d result beats:",
                 sb.bytes_fed, stories, popped);
        $display("  type %0d, subject %0d, body %0d, story end %0d; %0d failures",
                 sb.kind_seen[nfd_pkg::KIND_TYPE], sb.kind_seen[nfd_pkg::KIND_SUBJECT],
                 sb.kind_seen[nfd_pkg::KIND_BODY], sb.kind_seen[nfd_pkg::KIND_END],
                 sb.failures);
        if (sb.failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[files.f]
hw/rtl/nfd_pkg.sv
hw/rtl/nfd_line_ram.sv
hw/rtl/nfd_front.sv
hw/rtl/nfd_job_fifo.sv
hw/rtl/nfd_back.sv
hw/rtl/news_feed_line_deframer.sv
hw/rtl/nfd_checker.sv
verif/testbench.sv
